// File: design/flsa_pkg.sv
// Shared definitions for the free-list slot allocator.
// Action and status codes, config register indexes, port widths.
// No dependencies.
`default_nettype none

package flsa_pkg;

  localparam int POOL_SLOTS_DEF = 256;

  localparam int ACTION_W  = 2;
  localparam int SLOT_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int HDR_W     = 8;
  localparam int USE_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC     = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FREED     = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_INIT_DONE = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

endpackage

`default_nettype wire

// File: design/flsa_mem.sv
// Next-slot memory: one write port, one read port, registered read data.
// Standalone; no package use.
`default_nettype none

module flsa_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/free_list_slot_allocator_unit.sv
// Free-list slot allocator, top level. Uses flsa_pkg and flsa_mem.
// Free and empty allocate results come straight from the request; allocate adds one
// next-slot memory read; init makes one memory write per linked slot, if there are any.
// Throughput: one request in flight; the next is accepted once its result is in the
// output register, or after a result held behind rsp_stall has moved there.
// Sync reset clears head, empty flag and handshake state, not the next-slot memory.
`default_nettype none

module free_list_slot_allocator_unit #(
  parameter int POOL_SLOTS = flsa_pkg::POOL_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic [flsa_pkg::ACTION_W-1:0]  action,
  input  wire logic [flsa_pkg::SLOT_W-1:0]    slot,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic      [flsa_pkg::SLOT_W-1:0]    granted_slot,
  output logic      [flsa_pkg::STATUS_W-1:0]  status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [flsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [flsa_pkg::CFG_DAT_W-1:0] cfg_data
);

  import flsa_pkg::*;

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int NXT_W = $clog2(POOL_SLOTS + 1);
  localparam int END_W = (NXT_W > USE_W) ? NXT_W : USE_W;
  localparam logic [NXT_W-1:0] NO_NEXT  = NXT_W'(POOL_SLOTS);
  localparam logic [END_W-1:0] END_MAX  = END_W'(POOL_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_INIT_RUN,
    S_HOLD
  } state_t;

  state_t state;

  logic [HDR_W-1:0]    header_slots;
  logic [USE_W-1:0]    slots_in_use;
  logic [IDX_W-1:0]    head;
  logic                list_empty;
  logic [IDX_W-1:0]    ptr;
  logic [SLOT_W-1:0]   hold_granted;
  status_t             hold_status;

  logic [END_W-1:0]    end_eff;
  logic [END_W-1:0]    ptr_inc;
  logic                hdr_below_end;
  logic                in_range;
  logic                out_free;
  logic                accept;
  logic                rsp_load;

  logic                res_fire;
  logic [SLOT_W-1:0]   res_granted;
  status_t             res_status;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [NXT_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [NXT_W-1:0]    mem_rdata;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = out_free && (res_fire || state == S_HOLD);

  always_comb begin
    end_eff       = (END_W'(slots_in_use) > END_MAX) ? END_MAX : END_W'(slots_in_use);
    ptr_inc       = END_W'(ptr) + END_W'(1);
    hdr_below_end = END_W'(header_slots) < end_eff;
    in_range      = (slot >= header_slots) && (END_W'(slot) < end_eff);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(slot);
    mem_wdata = list_empty ? NO_NEXT : NXT_W'(head);
    if (state == S_INIT_RUN) begin
      mem_we    = 1'b1;
      mem_waddr = ptr;
      mem_wdata = (ptr_inc == end_eff) ? NO_NEXT : NXT_W'(ptr_inc);
    end else if (accept && action == ACT_FREE && in_range) begin
      mem_we = 1'b1;
    end
    mem_re = accept && action == ACT_ALLOC && !list_empty;
  end

  // result produced this cycle, if any
  always_comb begin
    res_fire    = 1'b0;
    res_granted = '0;
    res_status  = ST_INIT_DONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_INIT: begin
              res_fire   = !hdr_below_end;
              res_status = ST_INIT_DONE;
            end
            ACT_ALLOC: begin
              res_fire   = list_empty;
              res_status = ST_EMPTY;
            end
            ACT_FREE: begin
              res_fire   = 1'b1;
              res_status = in_range ? ST_FREED : ST_IGNORED;
            end
            default: ;
          endcase
        end
      end
      S_ALLOC_RD: begin
        res_fire    = 1'b1;
        res_granted = SLOT_W'(head);
        res_status  = ST_ALLOC;
      end
      S_INIT_RUN: begin
        res_fire   = (ptr_inc == end_eff);
        res_status = ST_INIT_DONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_slots <= HDR_W'(1);
      slots_in_use <= USE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_SLOTS: header_slots <= cfg_data[HDR_W-1:0];
        CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      head       <= '0;
      list_empty <= 1'b1;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_INIT: begin
                if (hdr_below_end) begin
                  head       <= IDX_W'(header_slots);
                  ptr        <= IDX_W'(header_slots);
                  list_empty <= 1'b0;
                  state      <= S_INIT_RUN;
                end else begin
                  head       <= '0;
                  list_empty <= 1'b1;
                end
              end
              ACT_ALLOC: begin
                if (!list_empty) begin
                  state <= S_ALLOC_RD;
                end
              end
              ACT_FREE: begin
                if (in_range) begin
                  head       <= IDX_W'(slot);
                  list_empty <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_ALLOC_RD: begin
          if (mem_rdata >= NO_NEXT) begin
            head       <= '0;
            list_empty <= 1'b1;
          end else begin
            head <= IDX_W'(mem_rdata);
          end
        end
        S_INIT_RUN: begin
          ptr <= ptr + IDX_W'(1);
        end
        S_HOLD: begin
          if (out_free) begin
            granted_slot <= hold_granted;
            status       <= hold_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // result goes straight to the output register when it is free
      if (res_fire) begin
        if (out_free) begin
          granted_slot <= res_granted;
          status       <= res_status;
          state        <= S_IDLE;
        end else begin
          hold_granted <= res_granted;
          hold_status  <= res_status;
          state        <= S_HOLD;
        end
      end
    end
  end

  flsa_mem #(
    .DEPTH (POOL_SLOTS),
    .AW    (IDX_W),
    .DW    (NXT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// File: design/flsa_checker.sv
// Port-level checks for the free-list slot allocator, bound to the top level.
// Uses flsa_pkg status codes.
`default_nettype none

module flsa_port_checks (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           req_valid,
  input wire logic                           req_stall,
  input wire logic [flsa_pkg::ACTION_W-1:0]  action,
  input wire logic [flsa_pkg::SLOT_W-1:0]    slot,
  input wire logic                           rsp_valid,
  input wire logic                           rsp_stall,
  input wire logic [flsa_pkg::SLOT_W-1:0]    granted_slot,
  input wire logic [flsa_pkg::STATUS_W-1:0]  status,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [flsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [flsa_pkg::CFG_DAT_W-1:0] cfg_data
);

  import flsa_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_slot) && $stable(status))
    else $error("result changed while stalled");

  // only an allocation carries a slot
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_ALLOC |-> granted_slot == '0)
    else $error("nonzero granted_slot on non-allocate result");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_INIT_DONE)
    else $error("status code out of range");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind free_list_slot_allocator_unit flsa_port_checks u_flsa_checker (.*);

`default_nettype wire
